// ===== rtl/core/tsa_pkg.sv =====
package tsa_pkg;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_OOM   = 2'd1,
    ST_FREED = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_FIND,
    S_FILL,
    S_TAKE,
    S_TAKE2,
    S_FDIV,
    S_FCHK,
    S_FWR,
    S_OUT
  } fsm_t;

  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned REG_W    = 11;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned IDX_W    = 2;

endpackage

// ===== rtl/core/tsa_if.sv =====
interface tsa_in_if;
  import tsa_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [1:0]          type_id;
  logic [OFFSET_W-1:0] free_offset;
  modport source (output valid, action, type_id, free_offset, input ready);
  modport sink (input valid, action, type_id, free_offset, output ready);
endinterface

interface tsa_out_if;
  import tsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [OFFSET_W-1:0] slot_offset;
  modport source (output valid, status, slot_offset, input ready);
  modport sink (input valid, status, slot_offset, output ready);
endinterface

// ===== rtl/core/typed_slab_allocator.sv =====
// Typed slab allocator over NUM_CHUNKS equal chunks of CHUNK_BYTES bytes.
// Requests arrive as beats on the in channel: action 0 allocates a slot of
// type_id, action 1 frees the slot at free_offset. Every request yields one
// beat on the out channel carrying a status and, for an allocate, the byte
// offset of the slot.
// The block handles one request at a time. in.ready is high only while the
// sequencer is idle. An allocate costs a chain walk over the chunks
// in the type's chain, plus, when a new chunk must be claimed, a shared
// restoring divider (one quotient bit per cycle), a scan of one chunk per
// cycle for the lowest unclaimed chunk and one ring entry per cycle to fill
// the new chunk's free ring. A free runs the same divider for the slot index
// and remainder. The worst allocate walks NUM_CHUNKS-1 full chunks, scans to
// the last chunk and fills a whole ring. The result is held in an output
// register until out.ready takes it; the block accepts no new request until
// then and is ready again in the cycle after the result is taken.
// Reset (synchronous, active high) releases every chunk, clears all chains
// and returns the slot size registers to 16. The free ring memory is not
// cleared; each entry is written before it is read.
module typed_slab_allocator
  import tsa_pkg::*;
#(
  parameter int unsigned NUM_CHUNKS     = 16,
  parameter int unsigned CHUNK_BYTES    = 1024,
  parameter int unsigned NUM_TYPES      = 4,
  parameter int unsigned MIN_SLOT_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst,
  tsa_in_if.sink           in,
  tsa_out_if.source        out,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int unsigned RING_DEPTH = CHUNK_BYTES / MIN_SLOT_BYTES;
  localparam int unsigned CW  = $clog2(NUM_CHUNKS + 1);
  localparam int unsigned CIW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned KW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned BW  = $clog2(CHUNK_BYTES);
  localparam int unsigned QW  = BW + 1;
  localparam int unsigned DCW = $clog2(QW + 1);
  localparam int unsigned TW  = $clog2(NUM_TYPES + 1);
  localparam int unsigned DW  = $clog2(NUM_CHUNKS * CHUNK_BYTES);
  localparam int unsigned MW  = (NUM_CHUNKS * RING_DEPTH > 1) ?
                                $clog2(NUM_CHUNKS * RING_DEPTH) : 1;
  localparam logic [CW-1:0] NONE = CW'(NUM_CHUNKS);
  localparam logic [TW-1:0] UNCL = TW'(NUM_TYPES);

  logic [REG_W-1:0] slot_reg [NUM_REGS];

  logic [TW-1:0] chunk_owner [NUM_CHUNKS];
  logic [KW-1:0] chunk_used  [NUM_CHUNKS];
  logic [KW-1:0] chunk_cap   [NUM_CHUNKS];
  logic [CW-1:0] chunk_next  [NUM_CHUNKS];
  logic [RW-1:0] chunk_head  [NUM_CHUNKS];
  logic [CW-1:0] type_first  [NUM_TYPES];

  logic [RW-1:0] ring [NUM_CHUNKS * RING_DEPTH];
  logic [RW-1:0] ring_rd;

  fsm_t state, state_next;

  logic                act;
  logic [1:0]          tid;
  logic [OFFSET_W-1:0] offs;
  logic [CW-1:0]       cur, last;
  logic [CW:0]         steps;
  logic [REG_W-1:0]    size;
  logic [KW-1:0]       fillcnt, cap_new;
  logic [1:0]          res_status;
  logic [OFFSET_W-1:0] res_offset;

  // Shared restoring divider: dividend dvd over divisor size.
  logic [QW-1:0]  dvd, quo;
  logic [REG_W:0] rem;
  logic [DCW-1:0] dcnt;
  logic [REG_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem[REG_W-1:0], dvd[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, size};

  logic [CIW-1:0] ci;
  assign ci = cur[CIW-1:0];
  logic [CIW-1:0] fi;

  logic [REG_W-1:0] eff_size;
  always_comb begin
    eff_size = slot_reg[tid];
    if (eff_size < REG_W'(MIN_SLOT_BYTES)) eff_size = REG_W'(MIN_SLOT_BYTES);
  end

  // Free offset decode.
  logic [DW-1:0] off_ext;
  logic [CW:0]   f_chunk;
  logic [CW:0]   in_chunk;
  assign off_ext = DW'(offs);
  assign f_chunk = (CW+1)'(32'(offs) / CHUNK_BYTES);
  assign in_chunk = (CW+1)'(32'(in.free_offset) / CHUNK_BYTES);

  logic [KW:0] tail_sum;
  logic [KW-1:0] tail;
  always_comb begin
    tail_sum = (KW+1)'(chunk_head[ci]) + (KW+1)'(chunk_cap[ci]) - (KW+1)'(chunk_used[ci]);
    tail = (tail_sum >= (KW+1)'(chunk_cap[ci])) ? KW'(tail_sum - (KW+1)'(chunk_cap[ci]))
                                                : KW'(tail_sum);
  end

  logic cur_ok;
  assign cur_ok = (cur < NONE) && (chunk_used[ci] < chunk_cap[ci]);

  logic [MW-1:0] rd_addr;
  assign rd_addr = MW'(32'(ci) * RING_DEPTH + 32'(chunk_head[ci]));

  always_ff @(posedge clk) begin
    ring_rd <= ring[rd_addr];
    if (state == S_FILL && fillcnt < cap_new)
      ring[MW'(32'(ci) * RING_DEPTH + 32'(fillcnt))] <= RW'(fillcnt);
    else if (state == S_FWR)
      ring[MW'(32'(ci) * RING_DEPTH + 32'(tail))] <= RW'(quo);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in.valid) state_next = (in.action == ACT_FREE) ? S_FDIV : S_WALK;
      S_WALK: begin
        if (32'(tid) >= NUM_TYPES) state_next = S_OUT;
        else if (cur_ok) state_next = S_TAKE;
        else if (cur >= NONE || steps >= (CW+1)'(NUM_CHUNKS)) state_next = S_DIV;
      end
      S_DIV:   if (dcnt == 0) state_next = S_FIND;
      S_FIND: begin
        if (quo == '0 || 32'(quo) > RING_DEPTH || cur >= NONE) state_next = S_OUT;
        else if (chunk_owner[ci] == UNCL) state_next = S_FILL;
      end
      S_FILL:  if (fillcnt + 1'b1 >= cap_new) state_next = S_TAKE;
      S_TAKE:  state_next = S_TAKE2;
      S_TAKE2: state_next = S_OUT;
      S_FDIV:  if (dcnt == 0) state_next = S_FCHK;
      S_FCHK:  state_next = S_OUT;
      S_FWR:   state_next = S_OUT;
      S_OUT:   if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_FCHK) begin
      if (!(f_chunk >= (CW+1)'(NUM_CHUNKS) || chunk_owner[ci] >= UNCL ||
            chunk_used[ci] == '0 || rem != '0 || 32'(quo) >= 32'(chunk_cap[ci])))
        state_next = S_FWR;
    end
  end

  // Outputs.
  always_comb begin
    in.ready = (state == S_IDLE);
    out.valid = (state == S_OUT);
    out.status = res_status;
    out.slot_offset = res_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_REGS; i++) slot_reg[i] <= REG_W'(16);
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        chunk_owner[i] <= UNCL;
        chunk_used[i]  <= '0;
        chunk_cap[i]   <= '0;
        chunk_next[i]  <= NONE;
        chunk_head[i]  <= '0;
      end
      for (int i = 0; i < NUM_TYPES; i++) type_first[i] <= NONE;
    end else begin
      state <= state_next;
      if (cfg_we) slot_reg[cfg_index] <= cfg_data;
      unique case (state)
        S_IDLE: if (in.valid) begin
          act <= in.action;
          tid <= in.type_id;
          offs <= in.free_offset;
          last <= NONE;
          steps <= '0;
          res_status <= ST_OOM;
          res_offset <= '0;
          cur <= (32'(in.type_id) < NUM_TYPES) ? type_first[in.type_id[TW-2:0]] : NONE;
        end
        S_WALK: begin
          size <= eff_size;
          dvd <= QW'(CHUNK_BYTES);
          quo <= '0;
          rem <= '0;
          dcnt <= DCW'(QW);
          if (!cur_ok && cur < NONE && steps < (CW+1)'(NUM_CHUNKS)) begin
            last <= cur;
            cur <= chunk_next[ci];
            steps <= steps + 1'b1;
          end
        end
        S_DIV, S_FDIV: begin
          if (dcnt != 0) begin
            rem <= rem_ge ? rem_sh - {1'b0, size} : rem_sh;
            quo <= {quo[QW-2:0], rem_ge};
            dvd <= {dvd[QW-2:0], 1'b0};
            dcnt <= dcnt - 1'b1;
          end
          if (state == S_DIV && dcnt == 0) begin
            cur <= '0;
            cap_new <= KW'(quo);
            fillcnt <= '0;
          end
          if (state == S_FDIV && dcnt == 0) cur <= f_chunk[CW-1:0];
        end
        S_FIND: if (chunk_owner[ci] != UNCL && cur < NONE) cur <= cur + 1'b1;
          else if (chunk_owner[ci] == UNCL && quo != '0 && 32'(quo) <= RING_DEPTH
                   && cur < NONE) begin
          chunk_owner[ci] <= TW'(tid);
          chunk_used[ci] <= '0;
          chunk_cap[ci] <= cap_new;
          chunk_next[ci] <= NONE;
          chunk_head[ci] <= '0;
          if (last < NONE) chunk_next[last[CIW-1:0]] <= cur;
          if (type_first[tid[TW-2:0]] >= NONE) type_first[tid[TW-2:0]] <= cur;
        end
        S_FILL: fillcnt <= fillcnt + 1'b1;
        S_TAKE: begin
          // ring_rd is valid next cycle; head read address stable now.
        end
        S_TAKE2: begin
          res_status <= ST_ALLOC;
          res_offset <= OFFSET_W'(32'(ci) * CHUNK_BYTES + 32'(ring_rd) * 32'(size));
          chunk_head[ci] <= (32'(chunk_head[ci]) + 1 >= 32'(chunk_cap[ci])) ? '0
                            : chunk_head[ci] + 1'b1;
          chunk_used[ci] <= chunk_used[ci] + 1'b1;
        end
        S_FCHK: res_status <= ST_BAD;
        S_FWR: begin
          res_status <= ST_FREED;
          chunk_used[ci] <= chunk_used[ci] - 1'b1;
        end
        S_OUT: ;
        default: ;
      endcase
      // A free takes the divisor from the owner of the addressed chunk, so it
      // is ready before the first divider step.
      if (state == S_IDLE && in.valid && in.action == ACT_FREE) begin
        dvd <= QW'(32'(in.free_offset) % CHUNK_BYTES);
        quo <= '0;
        rem <= '0;
        dcnt <= DCW'(QW);
        size <= (slot_reg[chunk_owner[fi][1:0]] < REG_W'(MIN_SLOT_BYTES))
                ? REG_W'(MIN_SLOT_BYTES) : slot_reg[chunk_owner[fi][1:0]];
      end
    end
  end

  // Chunk index of the offset on the input, replaced by zero when out of range for lookups.
  assign fi = (in_chunk < (CW+1)'(NUM_CHUNKS)) ? CIW'(in_chunk) : '0;

  logic unused_ok;
  assign unused_ok = ^{act, off_ext};

endmodule

// ===== rtl/core/tsa_checker.sv =====
module tsa_checker
  import tsa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [OFFSET_W-1:0] out_slot_offset
);

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");

  a_zero_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_ALLOC |-> out_slot_offset == '0)
    else $error("nonzero offset on non-allocate result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted two beats");

endmodule

bind typed_slab_allocator tsa_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .out_status(out.status), .out_slot_offset(out.slot_offset)
);

// ===== tb/sv/tb.sv =====
module tb;
  import tsa_pkg::*;

  localparam int unsigned NCH    = 16;
  localparam int unsigned CBYTES = 1024;
  localparam int unsigned NTYPES = 4;
  localparam int unsigned MINSZ  = 16;
  localparam int unsigned RDEPTH = CBYTES / MINSZ;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  // Register indexes of the slot size registers.
  localparam logic [IDX_W-1:0] REG_SLOT_T0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_SLOT_T1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_SLOT_T2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SLOT_T3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  tsa_in_if  req_ch ();
  tsa_out_if rsp_ch ();

  typed_slab_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in        (req_ch.sink),
    .out       (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: slot size registers, chunk table and the
  // per-chunk free rings.
  logic [REG_W-1:0] slot_size_reg [NTYPES];
  logic [2:0]       owner_of  [NCH];
  logic [6:0]       used_of   [NCH];
  logic [6:0]       cap_of    [NCH];
  logic [4:0]       next_of   [NCH];
  logic [4:0]       head_of_type [NTYPES];
  logic [5:0]       ring_head [NCH];
  logic [5:0]       free_ring [NCH * RDEPTH];

  typedef struct packed {
    status_t              status;
    logic [OFFSET_W-1:0]  offset;
  } reply_t;

  reply_t pending_replies [$];
  int     fail_count = 0;
  int     idle_cycles = 0;

  // Receiver control: random stalls, plus a long hold-off on request.
  bit rx_hold = 1'b0;

  function automatic int unsigned size_of_type(int unsigned t);
    int unsigned s;
    s = slot_size_reg[t];
    if (s < MINSZ) s = MINSZ;
    return s;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < NTYPES; i++) begin
      slot_size_reg[i] = 11'd16;
      head_of_type[i] = 5'(NCH);
    end
    for (int i = 0; i < NCH; i++) begin
      owner_of[i] = 3'(NTYPES);
      used_of[i] = '0;
      cap_of[i] = '0;
      next_of[i] = 5'(NCH);
      ring_head[i] = '0;
    end
  endfunction

  // Allocate: walk the chain for a chunk with room, claim a new one if none.
  function automatic reply_t predict_alloc(int unsigned t);
    int unsigned c, last, steps, sz, cap, slot, h;
    reply_t r;
    r.status = ST_OOM;
    r.offset = '0;
    sz = size_of_type(t);
    c = head_of_type[t];
    last = NCH;
    steps = 0;
    while (c < NCH && steps < NCH && used_of[c] >= cap_of[c]) begin
      last = c;
      c = next_of[c];
      steps++;
    end
    if (!(c < NCH && used_of[c] < cap_of[c])) begin
      cap = CBYTES / sz;
      if (cap == 0) return r;
      for (c = 0; c < NCH; c++)
        if (owner_of[c] == NTYPES) break;
      if (c >= NCH) return r;
      owner_of[c] = 3'(t);
      used_of[c] = '0;
      cap_of[c] = 7'(cap);
      next_of[c] = 5'(NCH);
      ring_head[c] = '0;
      for (int i = 0; i < cap && i < RDEPTH; i++) free_ring[c * RDEPTH + i] = 6'(i);
      if (last < NCH) next_of[last] = 5'(c);
      if (head_of_type[t] >= NCH) head_of_type[t] = 5'(c);
    end
    cap = cap_of[c];
    h = ring_head[c] % RDEPTH;
    slot = free_ring[c * RDEPTH + h];
    ring_head[c] = 6'((ring_head[c] + 1) % cap);
    used_of[c] = 7'(used_of[c] + 1);
    r.status = ST_ALLOC;
    r.offset = OFFSET_W'(c * CBYTES + slot * sz);
    return r;
  endfunction

  // Free: decode chunk and slot, push the slot at the ring tail.
  function automatic reply_t predict_free(int unsigned off);
    int unsigned c, chunk_pos, sz, slot, cap, tail;
    reply_t r;
    r.status = ST_BAD;
    r.offset = '0;
    c = off / CBYTES;
    if (c >= NCH || owner_of[c] >= NTYPES || used_of[c] == 0) return r;
    cap = cap_of[c];
    sz = size_of_type(owner_of[c]);
    chunk_pos = off % CBYTES;
    if (chunk_pos % sz != 0) return r;
    slot = chunk_pos / sz;
    if (cap == 0 || slot >= cap) return r;
    tail = (ring_head[c] + cap - used_of[c]) % cap;
    free_ring[c * RDEPTH + (tail % RDEPTH)] = 6'(slot);
    used_of[c] = 7'(used_of[c] - 1);
    r.status = ST_FREED;
    return r;
  endfunction

  // Offsets handed out so far, used to build well-formed frees.
  logic [OFFSET_W-1:0] live_offsets [$];

  // One request beat: drive, wait for acceptance, then predict. A literal
  // expectation, when given, is checked against the prediction too.
  task automatic send_request(action_t act, logic [1:0] t, logic [OFFSET_W-1:0] off,
                              bit has_lit, status_t lit_st, logic [OFFSET_W-1:0] lit_off);
    reply_t r;
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.type_id <= t;
    req_ch.free_offset <= off;
    do @(posedge clk); while (!req_ch.ready);
    if (act == ACT_ALLOC) r = predict_alloc(t);
    else r = predict_free(off);
    if (has_lit && (r.status !== lit_st || r.offset !== lit_off)) begin
      $error("table row: expected %0d/%0d, predictor gives %0d/%0d",
             lit_st, lit_off, r.status, r.offset);
      fail_count++;
    end
    pending_replies.push_back(r);
    if (r.status == ST_ALLOC) live_offsets.push_back(r.offset);
    // Random gap on the sender side, mostly short, sometimes long.
    if ($urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // One register write; the enable drops for a cycle before the next write.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_size_reg[idx] = val;
    @(posedge clk);
  endtask

  // Wait until the block is idle before touching the registers.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed table: action, type, offset, whether a literal is given, and
  // the literal status and offset.
  typedef struct {
    action_t             act;
    logic [1:0]          t;
    logic [OFFSET_W-1:0] off;
    bit                  lit;
    status_t             st;
    logic [OFFSET_W-1:0] res;
  } row_t;

  row_t dir_rows [] = '{
    '{ACT_ALLOC, 2'd0, 14'd0,     1'b1, ST_ALLOC, 14'd0},
    '{ACT_ALLOC, 2'd0, 14'd0,     1'b1, ST_ALLOC, 14'd16},
    '{ACT_ALLOC, 2'd3, 14'd0,     1'b1, ST_ALLOC, 14'd1024},
    '{ACT_FREE,  2'd0, 14'd0,     1'b1, ST_FREED, 14'd0},
    '{ACT_FREE,  2'd0, 14'd0,     1'b0, ST_FREED, 14'd0},  // repeated free
    '{ACT_FREE,  2'd0, 14'd0,     1'b1, ST_BAD,   14'd0},  // used count zero
    '{ACT_FREE,  2'd0, 14'd1029,  1'b1, ST_BAD,   14'd0},  // misaligned
    '{ACT_FREE,  2'd0, 14'd16383, 1'b1, ST_BAD,   14'd0},  // unclaimed chunk
    '{ACT_FREE,  2'd1, 14'd1040,  1'b0, ST_BAD,   14'd0},
    '{ACT_ALLOC, 2'd1, 14'd16383, 1'b0, ST_BAD,   14'd0},
    '{ACT_ALLOC, 2'd2, 14'd0,     1'b0, ST_BAD,   14'd0}
  };

  // Receiver: random stalls, with a long hold-off when asked.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) rsp_ch.ready <= 1'b0;
      else if ($urandom_range(0, 4) == 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with no expectation: status %0d", rsp_ch.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.slot_offset !== want.offset) begin
          $error("slot_offset: expected %0d, got %0d", want.offset, rsp_ch.slot_offset);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Random size choice biased toward extremes and small slots.
  function automatic logic [REG_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd2047;
      3: return 11'd16;
      default: return REG_W'($urandom_range(16, 200));
    endcase
  endfunction

  initial begin
    logic [OFFSET_W-1:0] off;
    int idx;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ALLOC;
    req_ch.type_id = '0;
    req_ch.free_offset = '0;
    reset_shadow();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].t, dir_rows[i].off,
                   dir_rows[i].lit, dir_rows[i].st, dir_rows[i].res);
    wait_drained();

    // Slot larger than a chunk, and a size below the minimum.
    write_reg(REG_SLOT_T1, 11'd2047);
    write_reg(REG_SLOT_T2, 11'd0);
    write_reg(REG_SLOT_T3, 11'd1024);
    write_reg(REG_SLOT_T0, 11'd48);
    send_request(ACT_ALLOC, 2'd1, '0, 1'b0, ST_OOM, '0);
    send_request(ACT_ALLOC, 2'd2, '0, 1'b0, ST_OOM, '0);
    send_request(ACT_ALLOC, 2'd3, '0, 1'b0, ST_OOM, '0);
    send_request(ACT_ALLOC, 2'd3, '0, 1'b0, ST_OOM, '0);
    send_request(ACT_ALLOC, 2'd0, '0, 1'b0, ST_OOM, '0);
    wait_drained();

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int k = 0; k < 6; k++)
        send_request(ACT_ALLOC, 2'($urandom_range(0, 3)), '0, 1'b0, ST_OOM, '0);
    join

    // Random phases; each ends drained and picks new sizes. Resets of the
    // chunk pool never happen; frees return slots but never release a chunk.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_reg(REG_SLOT_T0, pick_size());
      write_reg(REG_SLOT_T1, pick_size());
      write_reg(REG_SLOT_T2, pick_size());
      write_reg(REG_SLOT_T3, pick_size());
      for (int k = 0; k < 125; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_request(ACT_ALLOC, 2'($urandom_range(0, 3)),
                                   OFFSET_W'($urandom), 1'b0, ST_OOM, '0);
          4, 5, 6, 7, 8: begin
            if (live_offsets.size() != 0) begin
              idx = $urandom_range(0, live_offsets.size() - 1);
              off = live_offsets[idx];
              live_offsets.delete(idx);
            end else begin
              off = OFFSET_W'($urandom);
            end
            send_request(ACT_FREE, 2'($urandom), off, 1'b0, ST_OOM, '0);
          end
          default: begin
            off = OFFSET_W'($urandom);
            send_request(ACT_FREE, 2'($urandom), off, 1'b0, ST_OOM, '0);
          end
        endcase
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
